// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL
// Clocked implication checks with an active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

// File: rtl/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// Operation and error codes plus controller/datapath handshake types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rau_pkg;

    localparam logic [2:0] FUNC_ADD = 3'd0;
    localparam logic [2:0] FUNC_SUB = 3'd1;
    localparam logic [2:0] FUNC_MUL = 3'd2;
    localparam logic [2:0] FUNC_CMP = 3'd3;

    localparam logic [1:0] ERR_OK   = 2'd0;
    localparam logic [1:0] ERR_ZERO = 2'd1;
    localparam logic [1:0] ERR_NEG  = 2'd2;

    typedef struct packed {
        logic load;
        logic mul_a;
        logic mul_b;
        logic mul_c;
        logic comb;
        logic gcd_init;
        logic gcd_step;
        logic div_init;
        logic div_step;
        logic out_load;
    } rau_cmd_t;

    typedef struct packed {
        logic err;
        logic is_cmp;
        logic gcd_done;
        logic div_done;
    } rau_status_t;

endpackage

// File: rtl/rau_datapath.sv
// ----------------------------------------------------------------------------
// rau_datapath
// Shared multiplier, binary gcd engine, twin restoring dividers, result reg.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rau_datapath #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic               clk,
    input  rau_pkg::rau_cmd_t  cmd,
    output rau_pkg::rau_status_t status,
    input  logic [127:0]       in_data,
    input  logic [2:0]         in_func,
    output logic [127:0]       out_data,
    output logic [4:0]         out_flags
);
    import rau_pkg::*;

    localparam int OW = OPERAND_WIDTH;
    localparam int PW = 2 * OPERAND_WIDTH;
    localparam int CW = $clog2(PW + 1);

    logic signed [OW-1:0] ln_reg, ld_reg, rn_reg, rd_reg;
    logic [2:0]           func_reg;
    logic [1:0]           err_reg;
    logic signed [PW-1:0] x_reg, y_reg, dp_reg, num_reg;
    logic [PW-1:0]        den_reg;
    logic                 lt_reg, gt_reg, eq_reg;
    logic [PW-1:0]        ga_reg, gb_reg;
    logic [CW-1:0]        k_reg, cnt_reg;
    logic [PW-1:0]        dvs_reg, qn_reg, qd_reg, remn_reg, remd_reg;
    logic [63:0]          onum_reg;
    logic [62:0]          oden_reg;
    logic                 olt_reg, ogt_reg, oeq_reg;
    logic [1:0]           oerr_reg;

    logic signed [OW-1:0] ld_in, rd_in, ma, mb;
    logic signed [PW-1:0] prod, num_mag_s;
    logic [1:0]           err_in;
    logic [PW:0]          tn, td;
    logic [PW-1:0]        num_mag;
    logic signed [PW-1:0] qn_signed;

    assign ld_in = in_data[32+OW-1:32];
    assign rd_in = in_data[96+OW-1:96];

    always_comb
    begin
        err_in = ERR_OK;
        if (ld_in == '0)
            err_in = ERR_ZERO;
        else if (ld_in[OW-1])
            err_in = ERR_NEG;
        else if (in_func <= FUNC_CMP)
        begin
            if (rd_in == '0)
                err_in = ERR_ZERO;
            else if (rd_in[OW-1])
                err_in = ERR_NEG;
        end
    end

    // operand routing for the shared multiplier
    always_comb
    begin
        ma = ld_reg;
        mb = rd_reg;
        if (cmd.mul_a)
        begin
            ma = ln_reg;
            mb = (func_reg == FUNC_MUL) ? rn_reg : rd_reg;
        end
        else if (cmd.mul_b)
        begin
            ma = (func_reg == FUNC_MUL) ? ld_reg : rn_reg;
            mb = (func_reg == FUNC_MUL) ? rd_reg : ld_reg;
        end
    end

    assign prod      = PW'(ma) * PW'(mb);
    assign num_mag_s = num_reg[PW-1] ? -num_reg : num_reg;
    assign num_mag   = num_mag_s;
    assign tn        = {remn_reg, qn_reg[PW-1]};
    assign td        = {remd_reg, qd_reg[PW-1]};
    assign qn_signed = num_reg[PW-1] ? -qn_reg : qn_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ln_reg   <= in_data[OW-1:0];
            ld_reg   <= ld_in;
            rn_reg   <= in_data[64+OW-1:64];
            rd_reg   <= rd_in;
            func_reg <= in_func;
            err_reg  <= err_in;
        end
        if (cmd.mul_a)
            x_reg <= prod;
        if (cmd.mul_b)
            y_reg <= prod;
        if (cmd.mul_c)
            dp_reg <= prod;
        if (cmd.comb)
        begin
            lt_reg <= 1'b0;
            gt_reg <= 1'b0;
            eq_reg <= 1'b0;
            case (func_reg)
                FUNC_ADD:
                begin
                    num_reg <= x_reg + y_reg;
                    den_reg <= dp_reg;
                end
                FUNC_SUB:
                begin
                    num_reg <= x_reg - y_reg;
                    den_reg <= dp_reg;
                end
                FUNC_MUL:
                begin
                    num_reg <= x_reg;
                    den_reg <= y_reg;
                end
                FUNC_CMP:
                begin
                    lt_reg <= x_reg < y_reg;
                    gt_reg <= x_reg > y_reg;
                    eq_reg <= x_reg == y_reg;
                end
                default:
                begin
                    num_reg <= PW'(ln_reg);
                    den_reg <= PW'(ld_reg);
                end
            endcase
        end
        if (cmd.gcd_init)
        begin
            ga_reg <= num_mag;
            gb_reg <= den_reg;
            k_reg  <= '0;
        end
        else if (cmd.gcd_step)
        begin
            if (!ga_reg[0] && !gb_reg[0])
            begin
                ga_reg <= ga_reg >> 1;
                gb_reg <= gb_reg >> 1;
                k_reg  <= k_reg + 1'b1;
            end
            else if (!ga_reg[0])
                ga_reg <= ga_reg >> 1;
            else if (!gb_reg[0])
                gb_reg <= gb_reg >> 1;
            else if (ga_reg >= gb_reg)
                ga_reg <= ga_reg - gb_reg;
            else
                gb_reg <= gb_reg - ga_reg;
        end
        if (cmd.div_init)
        begin
            dvs_reg  <= gb_reg << k_reg;
            qn_reg   <= num_mag;
            qd_reg   <= den_reg;
            remn_reg <= '0;
            remd_reg <= '0;
            cnt_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (tn >= {1'b0, dvs_reg})
            begin
                remn_reg <= PW'(tn - {1'b0, dvs_reg});
                qn_reg   <= {qn_reg[PW-2:0], 1'b1};
            end
            else
            begin
                remn_reg <= tn[PW-1:0];
                qn_reg   <= {qn_reg[PW-2:0], 1'b0};
            end
            if (td >= {1'b0, dvs_reg})
            begin
                remd_reg <= PW'(td - {1'b0, dvs_reg});
                qd_reg   <= {qd_reg[PW-2:0], 1'b1};
            end
            else
            begin
                remd_reg <= td[PW-1:0];
                qd_reg   <= {qd_reg[PW-2:0], 1'b0};
            end
        end
        if (cmd.out_load)
        begin
            onum_reg <= '0;
            oden_reg <= '0;
            olt_reg  <= 1'b0;
            ogt_reg  <= 1'b0;
            oeq_reg  <= 1'b0;
            oerr_reg <= err_reg;
            if (err_reg == ERR_OK)
            begin
                if (func_reg == FUNC_CMP)
                begin
                    olt_reg <= lt_reg;
                    ogt_reg <= gt_reg;
                    oeq_reg <= eq_reg;
                end
                else
                begin
                    onum_reg <= 64'(qn_signed);
                    oden_reg <= 63'(qd_reg);
                end
            end
        end
    end

    assign status.err      = (err_reg != ERR_OK);
    assign status.is_cmp   = (func_reg == FUNC_CMP);
    assign status.gcd_done = (ga_reg == '0);
    assign status.div_done = (cnt_reg == CW'(PW));

    assign out_data  = {1'b0, oden_reg, onum_reg};
    assign out_flags = {oerr_reg, oeq_reg, ogt_reg, olt_reg};

endmodule

// File: rtl/rau_ctrl.sv
// ----------------------------------------------------------------------------
// rau_ctrl
// Sequencer for multiply, gcd and divide phases, and the output valid flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module rau_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rau_pkg::rau_cmd_t    cmd,
    input  rau_pkg::rau_status_t status
);
    import rau_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE     = 10'b0000000001,
        S_MUL_A    = 10'b0000000010,
        S_MUL_B    = 10'b0000000100,
        S_MUL_C    = 10'b0000001000,
        S_COMB     = 10'b0000010000,
        S_GCD_INIT = 10'b0000100000,
        S_GCD_RUN  = 10'b0001000000,
        S_DIV_INIT = 10'b0010000000,
        S_DIV_RUN  = 10'b0100000000,
        S_FINISH   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic   valid_reg, valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL_A;
                end
            end
            S_MUL_A:
            begin
                cmd.mul_a  = 1'b1;
                state_next = status.err ? S_FINISH : S_MUL_B;
            end
            S_MUL_B:
            begin
                cmd.mul_b  = 1'b1;
                state_next = S_MUL_C;
            end
            S_MUL_C:
            begin
                cmd.mul_c  = 1'b1;
                state_next = S_COMB;
            end
            S_COMB:
            begin
                cmd.comb   = 1'b1;
                state_next = status.is_cmp ? S_FINISH : S_GCD_INIT;
            end
            S_GCD_INIT:
            begin
                cmd.gcd_init = 1'b1;
                state_next   = S_GCD_RUN;
            end
            S_GCD_RUN:
            begin
                if (status.gcd_done)
                    state_next = S_DIV_INIT;
                else
                    cmd.gcd_step = 1'b1;
            end
            S_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                state_next   = S_DIV_RUN;
            end
            S_DIV_RUN:
            begin
                if (status.div_done)
                    state_next = S_FINISH;
                else
                    cmd.div_step = 1'b1;
            end
            S_FINISH:
            begin
                // hold until the output register is free
                if (!valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.out_load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = valid_reg;

    `ASSERT_NXT(a_accept_busy, clk, rst_n, in_valid && in_ready, state_reg != S_IDLE)
    `ASSERT_NXT(a_load_valid, clk, rst_n, cmd.out_load, valid_reg)
    `ASSERT_NXT(a_finish_hold, clk, rst_n,
                (state_reg == S_FINISH) && valid_reg && !out_ready, state_reg == S_FINISH)

endmodule

// File: rtl/rational_arithmetic_unit_core.sv
// Error requests leave after the first multiply step and compare requests after the combine
// step, skipping the gcd and divide phases. The gcd loop is data dependent; each of the two
// dividers retires one quotient bit per cycle.
// One request in flight; the next is taken once the result sits in the output register.
// rst_n is asynchronous, active low, and clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_core
// Rational add, subtract, multiply, compare and reduce with gcd reduction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rational_arithmetic_unit_core #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,  // lhs_numer, lhs_denom, rhs_numer, rhs_denom
    input  logic [2:0]   s_tuser,  // func
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,  // res_numer, res_denom, pad
    output logic [4:0]   m_tuser   // is_less, is_greater, is_equal, error_code
);
    import rau_pkg::*;

    rau_cmd_t    cmd;
    rau_status_t status;

    rau_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd),
        .status    (status)
    );

    rau_datapath #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_dp (
        .clk       (clk),
        .cmd       (cmd),
        .status    (status),
        .in_data   (s_tdata),
        .in_func   (s_tuser),
        .out_data  (m_tdata),
        .out_flags (m_tuser)
    );

endmodule
